// ===== rtl/core/bthalloc_pkg.sv =====
// Package for the boundary-tag heap allocator: heap constants, tag layout,
// item structs, status codes and sequencer states. No dependencies.
`default_nettype none

package bthalloc_pkg;

  localparam int HEAP_GRANULES = 1024;
  localparam int GRAN_SHIFT    = 5;
  localparam int HDR_OFFSET    = 8;
  localparam int GA_W          = $clog2(HEAP_GRANULES);
  localparam int SZ_W          = GA_W + 1;
  localparam int TAG_W         = SZ_W + 1;
  localparam int REQ_W         = 15;
  localparam int BYTES_W       = 16;

  localparam logic [SZ_W-1:0]  HEAP_SZ  = SZ_W'(HEAP_GRANULES);
  localparam logic [SZ_W-1:0]  NO_POS   = SZ_W'(HEAP_GRANULES);
  localparam logic [TAG_W-1:0] INIT_TAG = {HEAP_SZ, 1'b0};

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_NEXT  = 2'd1,
    FIT_BEST  = 2'd2,
    FIT_ALT   = 2'd3
  } fit_policy_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_SIZE = 2'd1,
    ST_NO_FIT    = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_t;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_A_WR1,
    S_A_WR2,
    S_F_RD,
    S_F_CHK,
    S_F_NRD,
    S_F_MRG,
    S_F_WR,
    S_RESP
  } state_t;

  typedef struct packed {
    logic              req_type;
    logic [REQ_W-1:0]  request_size;
    logic [REQ_W-1:0]  block_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [REQ_W-1:0]   payload_address;
    logic [BYTES_W-1:0] block_bytes;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/boundary_tag_heap_allocator_top.sv =====
// Boundary-tag heap allocator with header and footer tag memories and one
// sequencer that walks the block chain. Depends on bthalloc_pkg.
//
// Allocate walks the block chain header by header, each header read going through the
// registered port of the header memory, then writes the remainder and the new tags.
// Free walks the chain to check the freed block, reads its neighbours' tags, merges.
// One item is in work at a time; the result waits in an output register, and the
// next item can be accepted once the result enters that register.
// After reset a clearing pass writes all 1024 entries of both tag memories before
// the first item is accepted; configuration writes are taken at all times.
`default_nettype none

module boundary_tag_heap_allocator_top
  import bthalloc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [1:0] cfg_data
);

  logic [TAG_W-1:0] hdr_mem [HEAP_GRANULES];
  logic [TAG_W-1:0] ftr_mem [HEAP_GRANULES];
  logic [TAG_W-1:0] hdr_q_r, ftr_q_r;

  state_t           state_r, state_nxt;
  logic [GA_W-1:0]  clr_r, clr_nxt;
  fit_policy_t      policy_r, policy_nxt;
  logic [SZ_W-1:0]  nfp_r, nfp_nxt;
  logic [SZ_W-1:0]  p_r, p_nxt;
  logic [SZ_W-1:0]  need_r, need_nxt;
  logic [GA_W-1:0]  g_r, g_nxt;
  logic [SZ_W-1:0]  s_r, s_nxt;
  logic [GA_W-1:0]  best_r, best_nxt;
  logic [SZ_W-1:0]  best_sz_r, best_sz_nxt;
  logic             best_ok_r, best_ok_nxt;
  out_item_t        res_r, res_nxt;
  out_item_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             hdr_we, ftr_we;
  logic [GA_W-1:0]  hdr_waddr, ftr_waddr, hdr_raddr, ftr_raddr;
  logic [TAG_W-1:0] hdr_wdata, ftr_wdata;

  logic [SZ_W-1:0]  s_h, ps, p_sum, nb, need_in;
  logic             u_h, u_f, chain_ok, fits, upd, p_match, nb_ok, accept, emit;
  logic             bad_align;
  logic [REQ_W-1:0] addr_off;

  assign s_h      = hdr_q_r[TAG_W-1:1];
  assign u_h      = hdr_q_r[0];
  assign ps       = ftr_q_r[TAG_W-1:1];
  assign u_f      = ftr_q_r[0];
  assign nb       = SZ_W'(g_r) + s_r;
  assign p_sum    = p_r + s_h;
  assign chain_ok = (s_h != '0) && (s_h <= HEAP_SZ - p_r);
  assign nb_ok    = (s_h != '0) && (s_h <= HEAP_SZ - nb);
  assign fits     = chain_ok && !u_h && (s_h >= need_r);
  assign upd      = fits && (!best_ok_r || (s_h < best_sz_r));
  assign p_match  = (p_r == SZ_W'(g_r));
  assign need_in  = SZ_W'(({1'b0, in_data.request_size} + 16'd15) >> GRAN_SHIFT) + 1'b1;
  assign addr_off = in_data.block_address - REQ_W'(HDR_OFFSET);
  assign bad_align = (in_data.block_address < REQ_W'(HDR_OFFSET))
                     || (addr_off[GRAN_SHIFT-1:0] != '0);
  assign accept   = in_valid && !in_stall;
  assign emit     = (state_r == S_RESP) && (!out_valid_r || !out_stall);

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign hdr_raddr = (state_r == S_F_NRD) ? nb[GA_W-1:0] : p_r[GA_W-1:0];
  assign ftr_raddr = g_r - 1'b1;

  function automatic out_item_t mk_res(status_t st, logic [GA_W-1:0] g,
                                       logic [SZ_W-1:0] sz);
    out_item_t r;
    r.status          = st;
    r.payload_address = REQ_W'((32'(g) << GRAN_SHIFT) + HDR_OFFSET);
    r.block_bytes     = BYTES_W'(32'(sz) << GRAN_SHIFT);
    if (st != ST_OK) begin
      r.payload_address = '0;
      r.block_bytes     = '0;
    end
    return r;
  endfunction

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == GA_W'(HEAP_GRANULES - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (in_data.req_type == REQ_ALLOC) begin
            if (in_data.request_size == '0 || need_in > HEAP_SZ) state_nxt = S_RESP;
            else state_nxt = S_A_RD;
          end else begin
            state_nxt = bad_align ? S_RESP : S_F_RD;
          end
        end
      end
      S_A_RD: state_nxt = S_A_CHK;
      S_A_CHK: begin
        if (policy_r == FIT_BEST) begin
          if (!chain_ok || p_sum >= HEAP_SZ) state_nxt = (upd || best_ok_r) ? S_A_WR1 : S_RESP;
          else state_nxt = S_A_RD;
        end else begin
          priority if (fits) state_nxt = S_A_WR1;
          else if (!chain_ok || p_sum >= HEAP_SZ) state_nxt = S_RESP;
          else state_nxt = S_A_RD;
        end
      end
      S_A_WR1: state_nxt = S_A_WR2;
      S_A_WR2: state_nxt = S_RESP;
      S_F_RD:  state_nxt = S_F_CHK;
      S_F_CHK: begin
        priority if (p_match) state_nxt = u_h ? S_F_NRD : S_RESP;
        else if (p_r > SZ_W'(g_r) || !chain_ok || p_sum >= HEAP_SZ) state_nxt = S_RESP;
        else state_nxt = S_F_RD;
      end
      S_F_NRD: state_nxt = S_F_MRG;
      S_F_MRG: state_nxt = S_F_WR;
      S_F_WR:  state_nxt = S_RESP;
      S_RESP:  if (emit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    logic [SZ_W-1:0] tot;
    logic [GA_W-1:0] st;
    logic [SZ_W-1:0] nf;
    clr_nxt       = clr_r;
    policy_nxt    = policy_r;
    nfp_nxt       = nfp_r;
    p_nxt         = p_r;
    need_nxt      = need_r;
    g_nxt         = g_r;
    s_nxt         = s_r;
    best_nxt      = best_r;
    best_sz_nxt   = best_sz_r;
    best_ok_nxt   = best_ok_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    hdr_we        = 1'b0;
    ftr_we        = 1'b0;
    hdr_waddr     = g_r;
    ftr_waddr     = g_r;
    hdr_wdata     = '0;
    ftr_wdata     = '0;
    tot           = s_r;
    st            = g_r;
    nf            = nfp_r;

    if (cfg_valid && cfg_ready) policy_nxt = fit_policy_t'(cfg_data);
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        clr_nxt   = clr_r + 1'b1;
        hdr_we    = 1'b1;
        ftr_we    = 1'b1;
        hdr_waddr = clr_r;
        ftr_waddr = clr_r;
        hdr_wdata = (clr_r == '0) ? INIT_TAG : '0;
        ftr_wdata = (clr_r == GA_W'(HEAP_GRANULES - 1)) ? INIT_TAG : '0;
      end
      S_IDLE: begin
        if (accept) begin
          need_nxt    = need_in;
          best_ok_nxt = 1'b0;
          g_nxt       = addr_off[REQ_W-1:GRAN_SHIFT];
          if (in_data.req_type == REQ_ALLOC) begin
            p_nxt = '0;
            if (policy_r == FIT_NEXT && nfp_r < NO_POS) p_nxt = nfp_r;
            if (in_data.request_size == '0) begin
              res_nxt = mk_res(ST_ZERO_SIZE, '0, '0);
            end else if (need_in > HEAP_SZ) begin
              res_nxt = mk_res(ST_NO_FIT, '0, '0);
              if (policy_r == FIT_NEXT) nfp_nxt = NO_POS;
            end
          end else begin
            p_nxt = '0;
            if (bad_align) res_nxt = mk_res(ST_BAD_FREE, '0, '0);
          end
        end
      end
      S_A_RD: ;
      S_A_CHK: begin
        p_nxt = p_sum;
        if (policy_r == FIT_BEST) begin
          if (upd) begin
            best_nxt    = p_r[GA_W-1:0];
            best_sz_nxt = s_h;
            best_ok_nxt = 1'b1;
          end
          g_nxt = upd ? p_r[GA_W-1:0] : best_r;
          s_nxt = upd ? s_h : best_sz_r;
          if ((!chain_ok || p_sum >= HEAP_SZ) && !upd && !best_ok_r)
            res_nxt = mk_res(ST_NO_FIT, '0, '0);
        end else begin
          g_nxt = p_r[GA_W-1:0];
          s_nxt = s_h;
          if (fits) begin
            if (policy_r == FIT_NEXT) nfp_nxt = p_r;
          end else if (!chain_ok || p_sum >= HEAP_SZ) begin
            res_nxt = mk_res(ST_NO_FIT, '0, '0);
            if (policy_r == FIT_NEXT) nfp_nxt = NO_POS;
          end
        end
      end
      S_A_WR1: begin
        hdr_we    = (s_r > need_r);
        ftr_we    = (s_r > need_r);
        hdr_waddr = g_r + need_r[GA_W-1:0];
        ftr_waddr = GA_W'(SZ_W'(g_r) + s_r - 1'b1);
        hdr_wdata = {s_r - need_r, 1'b0};
        ftr_wdata = {s_r - need_r, 1'b0};
      end
      S_A_WR2: begin
        hdr_we    = 1'b1;
        ftr_we    = 1'b1;
        hdr_waddr = g_r;
        ftr_waddr = GA_W'(SZ_W'(g_r) + need_r - 1'b1);
        hdr_wdata = {need_r, 1'b1};
        ftr_wdata = {need_r, 1'b1};
        res_nxt   = mk_res(ST_OK, g_r, need_r);
      end
      S_F_RD: ;
      S_F_CHK: begin
        p_nxt = p_sum;
        s_nxt = chain_ok ? s_h : '0;
        if (!(p_match && u_h) &&
            (p_match || p_r > SZ_W'(g_r) || !chain_ok || p_sum >= HEAP_SZ))
          res_nxt = mk_res(ST_BAD_FREE, '0, '0);
      end
      S_F_NRD: ;
      S_F_MRG: begin
        if (nb < HEAP_SZ && !u_h) begin
          tot = tot + (nb_ok ? s_h : '0);
          if (nf == nb) nf = SZ_W'(g_r);
        end
        if (g_r != '0 && !u_f && ps != '0 && ps <= SZ_W'(g_r)) begin
          st  = g_r - ps[GA_W-1:0];
          tot = tot + ps;
          if (nf == SZ_W'(g_r)) nf = SZ_W'(st);
        end
        g_nxt   = st;
        s_nxt   = tot;
        nfp_nxt = nf;
      end
      S_F_WR: begin
        hdr_we    = 1'b1;
        ftr_we    = (s_r != '0);
        hdr_waddr = g_r;
        ftr_waddr = GA_W'(SZ_W'(g_r) + s_r - 1'b1);
        hdr_wdata = {s_r, 1'b0};
        ftr_wdata = {s_r, 1'b0};
        res_nxt   = mk_res(ST_OK, g_r, s_r);
      end
      S_RESP: begin
        if (emit) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      policy_r    <= FIT_FIRST;
      nfp_r       <= NO_POS;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      policy_r    <= policy_nxt;
      nfp_r       <= nfp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r       <= p_nxt;
    need_r    <= need_nxt;
    g_r       <= g_nxt;
    s_r       <= s_nxt;
    best_r    <= best_nxt;
    best_sz_r <= best_sz_nxt;
    best_ok_r <= best_ok_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (hdr_we) hdr_mem[hdr_waddr] <= hdr_wdata;
    hdr_q_r <= hdr_mem[hdr_raddr];
  end

  always_ff @(posedge clk) begin
    if (ftr_we) ftr_mem[ftr_waddr] <= ftr_wdata;
    ftr_q_r <= ftr_mem[ftr_raddr];
  end

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the boundary-tag heap allocator: a scoreboard class
// predicts every result from its own copy of the tag memories and fit policy.
// Depends on bthalloc_pkg and boundary_tag_heap_allocator_top.
`timescale 1ns / 100ps

module tb_top;
  import bthalloc_pkg::*;

  class alloc_scoreboard;
    logic [TAG_W-1:0] hdr [HEAP_GRANULES];
    logic [TAG_W-1:0] ftr [HEAP_GRANULES];
    int unsigned      rover;
    fit_policy_t      policy;
    out_item_t        expected_q [$];
    logic [REQ_W-1:0] live_q [$];
    int               errors;

    function new();
      for (int i = 0; i < HEAP_GRANULES; i++) begin
        hdr[i] = '0;
        ftr[i] = '0;
      end
      put_tag(0, HEAP_GRANULES, 1'b0);
      rover  = HEAP_GRANULES;
      policy = FIT_FIRST;
      errors = 0;
    endfunction

    function void put_tag(int unsigned g, int unsigned sz, logic used);
      logic [TAG_W-1:0] t;
      t = {SZ_W'(sz), used};
      if (g < HEAP_GRANULES) hdr[g] = t;
      if (sz > 0 && g + sz - 1 < HEAP_GRANULES) ftr[g + sz - 1] = t;
    endfunction

    function int unsigned span_at(int unsigned g);
      int unsigned s;
      s = hdr[g][TAG_W-1:1];
      if (s == 0 || s > HEAP_GRANULES - g) return 0;
      return s;
    endfunction

    function int unsigned scan_first(int unsigned from, int unsigned need);
      int unsigned p, s;
      p = from;
      while (p < HEAP_GRANULES) begin
        s = span_at(p);
        if (s == 0) return HEAP_GRANULES;
        if (!hdr[p][0] && s >= need) return p;
        p += s;
      end
      return HEAP_GRANULES;
    endfunction

    function int unsigned scan_best(int unsigned need);
      int unsigned p, s, best, best_sz;
      p = 0;
      best = HEAP_GRANULES;
      best_sz = 0;
      while (p < HEAP_GRANULES) begin
        s = span_at(p);
        if (s == 0) break;
        if (!hdr[p][0] && s >= need && (best == HEAP_GRANULES || s < best_sz)) begin
          best = p;
          best_sz = s;
        end
        p += s;
      end
      return best;
    endfunction

    function bit on_chain(int unsigned g);
      int unsigned p, s;
      p = 0;
      while (p < HEAP_GRANULES) begin
        if (p == g) return 1;
        if (p > g) return 0;
        s = span_at(p);
        if (s == 0) return 0;
        p += s;
      end
      return 0;
    endfunction

    function out_item_t result_of(status_t st, int unsigned g, int unsigned gran);
      out_item_t r;
      r.status          = st;
      r.payload_address = (st == ST_OK) ? REQ_W'(g * 32 + HDR_OFFSET) : '0;
      r.block_bytes     = (st == ST_OK) ? BYTES_W'(gran * 32) : '0;
      return r;
    endfunction

    function out_item_t allocate(int unsigned n);
      int unsigned need, g, s;
      if (n == 0) return result_of(ST_ZERO_SIZE, 0, 0);
      need = (n + 15) / 32 + 1;
      if (need > HEAP_GRANULES) begin
        if (policy == FIT_NEXT) rover = HEAP_GRANULES;
        return result_of(ST_NO_FIT, 0, 0);
      end
      if (policy == FIT_NEXT) begin
        if (rover >= HEAP_GRANULES) rover = 0;
        g = scan_first(rover, need);
        rover = g;
      end else if (policy == FIT_BEST) begin
        g = scan_best(need);
      end else begin
        g = scan_first(0, need);
      end
      if (g >= HEAP_GRANULES) return result_of(ST_NO_FIT, 0, 0);
      s = hdr[g][TAG_W-1:1];
      if (s > need) put_tag(g + need, s - need, 1'b0);
      put_tag(g, need, 1'b1);
      live_q.push_back(REQ_W'(g * 32 + HDR_OFFSET));
      return result_of(ST_OK, g, need);
    endfunction

    function out_item_t release_block(int unsigned addr);
      int unsigned g, s, start, total, nb, ps;
      if (addr < HDR_OFFSET || (addr - HDR_OFFSET) % 32 != 0)
        return result_of(ST_BAD_FREE, 0, 0);
      g = (addr - HDR_OFFSET) / 32;
      if (g >= HEAP_GRANULES || !on_chain(g) || !hdr[g][0])
        return result_of(ST_BAD_FREE, 0, 0);
      s = span_at(g);
      start = g;
      total = s;
      nb = g + s;
      if (nb < HEAP_GRANULES && !hdr[nb][0]) begin
        total += span_at(nb);
        if (rover == nb) rover = g;
      end
      if (g > 0 && !ftr[g - 1][0]) begin
        ps = ftr[g - 1][TAG_W-1:1];
        if (ps > 0 && ps <= g) begin
          start = g - ps;
          total += ps;
          if (rover == g) rover = start;
        end
      end
      put_tag(start, total, 1'b0);
      foreach (live_q[i]) begin
        if (live_q[i] == REQ_W'(addr)) begin
          live_q.delete(i);
          break;
        end
      end
      return result_of(ST_OK, start, total);
    endfunction

    function void note_request(in_item_t it);
      if (it.req_type == REQ_ALLOC) expected_q.push_back(allocate(int'(it.request_size)));
      else expected_q.push_back(release_block(int'(it.block_address)));
    endfunction

    function void check_response(out_item_t got);
      out_item_t exp;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: %h", got);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
      if (got.payload_address !== exp.payload_address) begin
        $error("payload_address: expected %0d, got %0d",
               exp.payload_address, got.payload_address);
        errors++;
      end
      if (got.block_bytes !== exp.block_bytes) begin
        $error("block_bytes: expected %0d, got %0d", exp.block_bytes, got.block_bytes);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [1:0] cfg_data = '0;

  alloc_scoreboard sb = new();
  int idle_cycles = 0;
  int burst_left = 1;
  int accepted_items = 0;

  boundary_tag_heap_allocator_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_request(in_data);
        accepted_items <= accepted_items + 1;
      end
      if (out_valid && !out_stall) sb.check_response(out_data);
      if (cfg_valid && cfg_ready) sb.policy = fit_policy_t'(cfg_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // Receiver: changing stall patterns, with one long hold-off.
  initial begin
    int cyc;
    int mode;
    int hold_left;
    bit held;
    cyc = 0;
    mode = 0;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 300 == 0) mode = $urandom_range(0, 3);
      if (!held && accepted_items >= 300) begin
        held = 1'b1;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end
      else if (mode == 0) out_stall <= 1'b0;
      else if (mode == 1) out_stall <= ($urandom_range(0, 1) == 0);
      else if (mode == 2) out_stall <= ($urandom_range(0, 9) < 8);
      else out_stall <= ($urandom_range(0, 9) == 0);
    end
  end

  task automatic send_item(in_item_t it);
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 25)) @(posedge clk);
      end
    end
  endtask

  task automatic alloc_req(int unsigned n);
    in_item_t it;
    it.req_type      = REQ_ALLOC;
    it.request_size  = REQ_W'(n);
    it.block_address = REQ_W'($urandom);
    send_item(it);
  endtask

  task automatic free_req(int unsigned a);
    in_item_t it;
    it.req_type      = REQ_FREE;
    it.request_size  = REQ_W'($urandom);
    it.block_address = REQ_W'(a);
    send_item(it);
  endtask

  task automatic drain_and_set(fit_policy_t p);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    cfg_data  <= p;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_item();
    int r;
    int unsigned n;
    in_item_t it;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      it = in_item_t'(31'($urandom));
      send_item(it);
    end else if (sb.live_q.size() == 0 ||
                 (sb.live_q.size() < 120 && r < 55) || r < 25) begin
      r = $urandom_range(0, 99);
      if (r < 2) n = 0;
      else if (r < 8) n = $urandom_range(1, 32767);
      else n = $urandom_range(1, 160);
      alloc_req(n);
    end else if (r < 92) begin
      free_req(int'(sb.live_q[$urandom_range(0, sb.live_q.size() - 1)]));
    end else begin
      free_req($urandom_range(0, 32767));
    end
  endtask

  initial begin
    fit_policy_t phases [7];
    logic [REQ_W-1:0] a0;
    phases = '{FIT_FIRST, FIT_NEXT, FIT_BEST, FIT_ALT, FIT_NEXT, FIT_BEST, FIT_FIRST};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    drain_and_set(FIT_FIRST);

    alloc_req(0);
    alloc_req(32767);
    alloc_req(32752);
    free_req(8);
    free_req(8);
    free_req(0);
    free_req(7);
    free_req(32767);
    alloc_req(1);
    alloc_req(17);
    alloc_req(100);
    alloc_req(49);
    free_req(40);
    free_req(136);
    free_req(8);
    free_req(104);
    alloc_req(20000);
    alloc_req(20000);
    drain_and_set(FIT_BEST);
    a0 = REQ_W'(8);
    alloc_req(300);
    alloc_req(40);
    alloc_req(300);
    alloc_req(40);
    free_req(int'(a0));
    free_req(int'(a0) + 11 * 32 + 32 * 2);
    alloc_req(40);

    foreach (phases[i]) begin
      drain_and_set(phases[i]);
      for (int k = 0; k < 165; k++) random_item();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
